[rtl/bpcm_pkg.sv]
package bpcm_pkg;

   localparam int unsigned SEED_WIDTH  = 8;
   localparam int unsigned TAP_WIDTH   = 8;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned FIELD_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [SEED_WIDTH-1:0]  PATTERN_SEED_RESET   = 8'd255;
   localparam logic [SEED_WIDTH-1:0]  SIGNATURE_SEED_RESET = 8'd0;
   localparam logic [TAP_WIDTH-1:0]   TAP_MASK_RESET       = 8'd99;
   localparam logic [COUNT_WIDTH-1:0] PATTERN_TOTAL_RESET  = 16'd11;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX            = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_PATTERN_SEED   = 2'd0,
      CSR_SIGNATURE_SEED = 2'd1,
      CSR_TAP_MASK       = 2'd2,
      CSR_PATTERN_TOTAL  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CMP_EQUAL   = 3'b001,
      CMP_GREATER = 3'b010,
      CMP_LESS    = 3'b100
   } cmp_code_type;

endpackage

[rtl/bpcm_req_if.sv]
interface bpcm_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, input ready, output restart);
   modport sink (input valid, output ready, input restart);
endinterface

[rtl/bpcm_rsp_if.sv]
interface bpcm_rsp_if;
   import bpcm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] pattern;
   cmp_code_type           compare_code;
   logic [FIELD_WIDTH-1:0] signature;
   logic                   last_pattern;

   modport source (output valid, input ready, output pattern, output compare_code,
                   output signature, output last_pattern);
   modport sink (input valid, output ready, input pattern, input compare_code,
                 input signature, input last_pattern);
endinterface

[rtl/bpcm_csr_if.sv]
interface bpcm_csr_if;
   import bpcm_pkg::*;
   logic                      valid;
   logic                      ready;
   csr_index_type             index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, input ready, output index, output data);
   modport sink (input valid, output ready, input index, input data);
endinterface

[rtl/bist_prpg_compare_misr.sv]
// Channel  Dir  Fields                                            Protocol
// req_chan in   restart                                           valid/ready
// rsp_chan out  pattern, compare_code, signature, last_pattern    valid/ready
// csr_chan in   index, data                                       valid/ready, ready outside reset
//
// One word per clock: a request word is taken every cycle the result register is
// empty or being drained, and its result is registered and appears in the next cycle.
// The pattern, signature and count registers advance in the accepting cycle;
// the LFSR steps, half-compare and count logic lie between registers.
// Reset is synchronous: state returns to all-ones pattern, zero signature and count,
// and the configuration registers to their defaults. A stalled result holds.
module bist_prpg_compare_misr #(
   parameter int unsigned WIDTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   bpcm_req_if.sink          req_chan,
   bpcm_rsp_if.source        rsp_chan,
   bpcm_csr_if.sink          csr_chan
);
   import bpcm_pkg::*;

   localparam int unsigned LOAD_BITS = (WIDTH < SEED_WIDTH) ? WIDTH : SEED_WIDTH;
   localparam int unsigned OUT_BITS  = (WIDTH < FIELD_WIDTH) ? WIDTH : FIELD_WIDTH;
   localparam int unsigned INJ_TOP   = (WIDTH < 8) ? WIDTH : 8;

   logic [SEED_WIDTH-1:0]  pat_seed_ff, pat_seed_in;
   logic [SEED_WIDTH-1:0]  sig_seed_ff, sig_seed_in;
   logic [TAP_WIDTH-1:0]   tap_mask_ff, tap_mask_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic [WIDTH-1:0]       pattern_ff, pattern_in;
   logic [WIDTH-1:0]       signature_ff, signature_in;
   logic [COUNT_WIDTH-1:0] done_ff, done_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_pattern_ff, rsp_pattern_in;
   cmp_code_type           rsp_code_ff, rsp_code_in;
   logic [FIELD_WIDTH-1:0] rsp_signature_ff, rsp_signature_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic [WIDTH-1:0]       pat_seed_w, sig_seed_w;
   logic [WIDTH-1:0]       cur_pattern, cur_signature;
   logic [COUNT_WIDTH-1:0] cur_done;
   cmp_code_type           cmp_code;
   logic [WIDTH-1:0]       inject;
   logic [WIDTH-1:0]       pattern_next, signature_next;
   logic [FIELD_WIDTH-1:0] seed_view;

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = !reset;

   always_comb begin
      pat_seed_in = pat_seed_ff;
      sig_seed_in = sig_seed_ff;
      tap_mask_in = tap_mask_ff;
      total_in    = total_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_PATTERN_SEED:   pat_seed_in = csr_chan.data[SEED_WIDTH-1:0];
            CSR_SIGNATURE_SEED: sig_seed_in = csr_chan.data[SEED_WIDTH-1:0];
            CSR_TAP_MASK:       tap_mask_in = csr_chan.data[TAP_WIDTH-1:0];
            CSR_PATTERN_TOTAL:  total_in    = csr_chan.data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pat_seed_w = '0;
      sig_seed_w = '0;
      seed_view  = '0;
      for (int i = 0; i < LOAD_BITS; i++) begin
         pat_seed_w[i] = pat_seed_ff[i];
         sig_seed_w[i] = sig_seed_ff[i];
         seed_view[i]  = pat_seed_ff[i];
      end
      cur_pattern   = req_chan.restart ? pat_seed_w : pattern_ff;
      cur_signature = req_chan.restart ? sig_seed_w : signature_ff;
      cur_done      = req_chan.restart ? '0 : done_ff;
   end

   bpcm_compare #(.WIDTH(WIDTH)) u_compare (
      .pattern (cur_pattern),
      .code    (cmp_code)
   );

   always_comb begin
      inject = '0;
      for (int i = 5; i < INJ_TOP; i++) begin
         inject[i] = cmp_code[7-i];
      end
   end

   bpcm_lfsr_step #(.WIDTH(WIDTH)) u_prpg_step (
      .state      (cur_pattern),
      .taps       (tap_mask_ff),
      .inject     ({WIDTH{1'b0}}),
      .next_state (pattern_next)
   );

   bpcm_lfsr_step #(.WIDTH(WIDTH)) u_misr_step (
      .state      (cur_signature),
      .taps       (tap_mask_ff),
      .inject     (inject),
      .next_state (signature_next)
   );

   always_comb begin
      pattern_in   = pattern_ff;
      signature_in = signature_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pattern_in   = rsp_pattern_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_signature_in = rsp_signature_ff;
      rsp_last_in      = rsp_last_ff;
      if (req_accept) begin
         pattern_in   = pattern_next;
         signature_in = signature_next;
         done_in      = (cur_done != COUNT_MAX) ? cur_done + 1'b1 : cur_done;
         rsp_valid_in = 1'b1;
         rsp_pattern_in   = '0;
         rsp_signature_in = '0;
         for (int i = 0; i < OUT_BITS; i++) begin
            rsp_pattern_in[i]   = cur_pattern[i];
            rsp_signature_in[i] = cur_signature[i];
         end
         rsp_code_in = cmp_code;
         rsp_last_in = ({1'b0, cur_done} + 1'b1) == {1'b0, total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_seed_ff  <= PATTERN_SEED_RESET;
         sig_seed_ff  <= SIGNATURE_SEED_RESET;
         tap_mask_ff  <= TAP_MASK_RESET;
         total_ff     <= PATTERN_TOTAL_RESET;
         pattern_ff   <= '1;
         signature_ff <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_seed_ff  <= pat_seed_in;
         sig_seed_ff  <= sig_seed_in;
         tap_mask_ff  <= tap_mask_in;
         total_ff     <= total_in;
         pattern_ff   <= pattern_in;
         signature_ff <= signature_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pattern_ff   <= rsp_pattern_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_signature_ff <= rsp_signature_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pattern      = rsp_pattern_ff;
   assign rsp_chan.compare_code = rsp_code_ff;
   assign rsp_chan.signature    = rsp_signature_ff;
   assign rsp_chan.last_pattern = rsp_last_ff;

   a_code_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_code_ff))
      else $error("compare code not one-hot");

   a_restart_loads_seed: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.restart) |=> rsp_pattern_ff == $past(seed_view))
      else $error("restart did not load pattern seed");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (done_ff == COUNT_MAX && !(req_accept && req_chan.restart)) |=> done_ff == COUNT_MAX)
      else $error("pattern count wrapped");

   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

endmodule

[rtl/bpcm_lfsr_step.sv]
module bpcm_lfsr_step #(
   parameter int unsigned WIDTH = 8
) (
   input  logic [WIDTH-1:0]               state,
   input  logic [bpcm_pkg::TAP_WIDTH-1:0] taps,
   input  logic [WIDTH-1:0]               inject,
   output logic [WIDTH-1:0]               next_state
);
   import bpcm_pkg::*;

   localparam int unsigned TAP_ROWS = (WIDTH < TAP_WIDTH) ? WIDTH : TAP_WIDTH;

   logic [WIDTH-1:0] fb;

   always_comb begin
      fb = '0;
      for (int j = 0; j < TAP_ROWS; j++) begin
         fb[WIDTH-1-j] = taps[j] & state[0];
      end
      next_state = (state >> 1) ^ fb ^ inject;
   end
endmodule

[rtl/bpcm_compare.sv]
module bpcm_compare #(
   parameter int unsigned WIDTH = 8
) (
   input  logic [WIDTH-1:0]     pattern,
   output bpcm_pkg::cmp_code_type code
);
   import bpcm_pkg::*;

   localparam int unsigned LO_W = WIDTH / 2;
   localparam int unsigned UP_W = WIDTH - LO_W;

   logic [WIDTH-1:0] rev;
   logic [UP_W-1:0]  upper;
   logic [UP_W-1:0]  lower;

   always_comb begin
      for (int i = 0; i < WIDTH; i++) begin
         rev[WIDTH-1-i] = pattern[i];
      end
      upper = rev[WIDTH-1:LO_W];
      lower = UP_W'(rev[LO_W-1:0]);
      if (upper > lower) begin
         code = CMP_GREATER;
      end else if (upper < lower) begin
         code = CMP_LESS;
      end else begin
         code = CMP_EQUAL;
      end
   end
endmodule
